[rtl/deque_with_range_fill_macros.svh]
// Assertion macros shared by the deque RTL.
// Each macro takes a label, a property expression and a message string.
`ifndef DEQUE_WITH_RANGE_FILL_MACROS_SVH
`define DEQUE_WITH_RANGE_FILL_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge once reset has been released.
`define DWRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, during reset as well.
`define DWRF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DWRF_ASSERT(label, prop, msg)
`define DWRF_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[rtl/dwrf_pkg.sv]
package dwrf_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int MODE_W    = 3;

  // Operation codes carried on the mode field.
  localparam logic [MODE_W-1:0] MODE_ADD_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REM_FRONT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REM_BACK  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OUTPUT    = 3'd4;

endpackage

[rtl/deque_with_range_fill.sv]
// Bounded double-ended queue of signed 32-bit words held in a ring memory of DEPTH entries.
// Input channel (in_valid/in_ready) carries one command word: add front, add back,
// remove front, remove back or output. Result channel (out_valid/out_ready) returns
// the words that each command produces, with out_last on the final one.
// Adds push start, start+step, ... while the term is at most end_value and not below
// the smallest word, one term per cycle through one adder and a pair of bound compares;
// a full store ends the run with out_status set. Removals give one result word.
// Output reads the ring one entry at a time through the single registered memory
// read port, each entry read and then presented; an empty deque gives one word with
// out_empty_mark set. The block handles one command at a time: in_ready is high only
// when it is idle, so no new command is taken until the last result word has gone.
// A zero step, an unused mode or an empty output goes straight to its result word.
// A stalled receiver simply holds the current result word; nothing is lost.
// Synchronous active-low reset empties the deque and sets the head to zero; the
// memory contents are not cleared, as no entry is read before it is written.
`include "deque_with_range_fill_macros.svh"

module deque_with_range_fill #(
  parameter int DEPTH = dwrf_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [dwrf_pkg::MODE_W-1:0]  in_mode,
  input  logic signed [dwrf_pkg::DATA_W-1:0]  in_start_value,
  input  logic signed [dwrf_pkg::DATA_W-1:0]  in_step_size,
  input  logic signed [dwrf_pkg::DATA_W-1:0]  in_end_value,
  input  logic signed [dwrf_pkg::DATA_W-1:0]  in_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dwrf_pkg::DATA_W-1:0]  out_value,
  output logic                                out_last,
  output logic                                out_empty_mark,
  output logic                                out_status
);
  import dwrf_pkg::*;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  // Terms are kept two bits wider than a word so that one more step past the
  // bound can never wrap.
  localparam int TERM_W = DATA_W + 2;

  localparam logic [SUM_W-1:0]         DEPTH_S  = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0]         DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0]         LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic signed [TERM_W-1:0] TERM_MIN =
    $signed({{(TERM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_REM  = 5'b00100,
    S_RD   = 5'b01000,
    S_SEND = 5'b10000
  } state_t;

  // Ring memory; the read data is registered.
  logic [DATA_W-1:0] mem [DEPTH];

  state_t                     state_r,  state_nxt;
  logic [IDX_W-1:0]           head_r,   head_nxt;
  logic [CNT_W-1:0]           count_r,  count_nxt;
  logic [CNT_W-1:0]           k_r,      k_nxt;
  logic [MODE_W-1:0]          mode_r,   mode_nxt;
  logic signed [DATA_W-1:0]   step_r,   step_nxt;
  logic signed [DATA_W-1:0]   end_r,    end_nxt;
  logic signed [DATA_W-1:0]   cnt_r,    cnt_nxt;
  logic signed [TERM_W-1:0]   term_r,   term_nxt;
  logic                       last_r,   last_nxt;
  logic                       empty_r,  empty_nxt;
  logic                       status_r, status_nxt;
  logic                       sel_mem_r, sel_mem_nxt;
  logic [DATA_W-1:0]          rd_data_r;

  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;

  logic [IDX_W-1:0]           front_idx;
  logic [SUM_W-1:0]           back_sum, back_wrap;
  logic [SUM_W-1:0]           rd_sum,   rd_wrap;
  logic [CNT_W-1:0]           rem_k;
  logic [SUM_W-1:0]           rem_sum,  rem_wrap;
  logic [CNT_W-1:0]           k_inc;
  logic signed [TERM_W-1:0]   end_ext;
  logic signed [TERM_W-1:0]   step_ext;
  logic                       term_done;
  logic                       store_full;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_SEND);

  assign out_value      = sel_mem_r ? $signed(rd_data_r) : '0;
  assign out_last       = last_r;
  assign out_empty_mark = empty_r;
  assign out_status     = status_r;

  // Ring address arithmetic. Every sum stays below twice the depth, so one
  // compare and subtract wraps it.
  assign front_idx = (head_r == '0) ? LAST_IDX : head_r - IDX_W'(1);
  assign back_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign back_wrap = (back_sum >= DEPTH_S) ? back_sum - DEPTH_S : back_sum;
  assign rd_sum    = SUM_W'(head_r) + SUM_W'(k_r);
  assign rd_wrap   = (rd_sum >= DEPTH_S) ? rd_sum - DEPTH_S : rd_sum;
  assign rd_addr   = rd_wrap[IDX_W-1:0];

  // Number of entries a removal drops: the request, clipped to the fill level.
  assign rem_k    = (cnt_r >= $signed(DATA_W'(count_r))) ? count_r : cnt_r[CNT_W-1:0];
  assign rem_sum  = SUM_W'(head_r) + SUM_W'(rem_k);
  assign rem_wrap = (rem_sum >= DEPTH_S) ? rem_sum - DEPTH_S : rem_sum;

  assign k_inc = k_r + CNT_W'(1);

  // The shared term unit: two compares, one against each bound, and one add.
  assign end_ext    = $signed({{(TERM_W-DATA_W){end_r[DATA_W-1]}}, end_r});
  assign step_ext   = $signed({{(TERM_W-DATA_W){step_r[DATA_W-1]}}, step_r});
  assign term_done  = (term_r > end_ext) || (term_r < TERM_MIN);
  assign store_full = (count_r == DEPTH_C);

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    k_nxt       = k_r;
    mode_nxt    = mode_r;
    step_nxt    = step_r;
    end_nxt     = end_r;
    cnt_nxt     = cnt_r;
    term_nxt    = term_r;
    last_nxt    = last_r;
    empty_nxt   = empty_r;
    status_nxt  = status_r;
    sel_mem_nxt = sel_mem_r;
    wr_en       = 1'b0;
    wr_addr     = front_idx;
    rd_en       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt    = in_mode;
          step_nxt    = in_step_size;
          end_nxt     = in_end_value;
          cnt_nxt     = in_count;
          term_nxt    = $signed({{(TERM_W-DATA_W){in_start_value[DATA_W-1]}},
                                 in_start_value});
          k_nxt       = '0;
          last_nxt    = 1'b1;
          empty_nxt   = 1'b0;
          status_nxt  = 1'b0;
          sel_mem_nxt = 1'b0;
          case (in_mode)
            MODE_ADD_FRONT, MODE_ADD_BACK: begin
              // A zero step leaves the deque alone.
              state_nxt = (in_step_size == '0) ? S_SEND : S_ADD;
            end
            MODE_REM_FRONT, MODE_REM_BACK: begin
              state_nxt = S_REM;
            end
            MODE_OUTPUT: begin
              if (count_r == '0) begin
                empty_nxt = 1'b1;
                state_nxt = S_SEND;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: begin
              state_nxt = S_SEND;
            end
          endcase
        end
      end

      S_ADD: begin
        if (term_done) begin
          state_nxt = S_SEND;
        end else if (store_full) begin
          status_nxt = 1'b1;
          state_nxt  = S_SEND;
        end else begin
          wr_en = 1'b1;
          if (mode_r == MODE_ADD_FRONT) begin
            wr_addr  = front_idx;
            head_nxt = front_idx;
          end else begin
            wr_addr = back_wrap[IDX_W-1:0];
          end
          count_nxt = count_r + CNT_W'(1);
          term_nxt  = term_r + step_ext;
        end
      end

      S_REM: begin
        if (cnt_r > $signed(DATA_W'(0))) begin
          count_nxt = count_r - rem_k;
          if (count_r == rem_k) begin
            head_nxt = '0;
          end else if (mode_r == MODE_REM_FRONT) begin
            head_nxt = rem_wrap[IDX_W-1:0];
          end
        end
        state_nxt = S_SEND;
      end

      S_RD: begin
        rd_en       = 1'b1;
        sel_mem_nxt = 1'b1;
        last_nxt    = (k_inc == count_r);
        state_nxt   = S_SEND;
      end

      S_SEND: begin
        if (out_ready) begin
          if (sel_mem_r && !last_r) begin
            k_nxt     = k_inc;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    mode_r    <= mode_nxt;
    step_r    <= step_nxt;
    end_r     <= end_nxt;
    cnt_r     <= cnt_nxt;
    term_r    <= term_nxt;
    last_r    <= last_nxt;
    empty_r   <= empty_nxt;
    status_r  <= status_nxt;
    sel_mem_r <= sel_mem_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= term_r[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  `DWRF_ASSERT(a_count_bound, count_r <= DEPTH_C, "fill level exceeds the depth")
  `DWRF_ASSERT(a_one_side, !(in_ready && out_valid), "ready and result at once")
  `DWRF_ASSERT(a_empty_head, (count_r == '0) |-> (head_r == '0), "empty deque off head zero")
  `DWRF_ASSERT(a_full_status, (out_valid && out_status) |-> store_full, "full status not full")
  `DWRF_ASSERT(a_empty_mark, (out_valid && out_empty_mark) |-> (count_r == '0),
               "empty mark with entries")

endmodule
